FILE: rtl/pbbf_pkg.sv
// ----------------------------------------------------------------------------
// Patterned blocked Bloom filter package
// Shared constants, opcode codes and the elaboration-time build of the
// 1088-bit pattern ROM from which the per-key masks are cut.
// ----------------------------------------------------------------------------
package pbbf_pkg;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WIN_BITS   = 57;
  localparam int unsigned SEL_BITS   = 10;
  localparam int unsigned ROT_BITS   = 6;
  localparam int unsigned FEW_SET    = 4;
  localparam int unsigned MANY_SET   = 5;
  localparam int unsigned COUNT_SPAN = MANY_SET - FEW_SET + 1;
  localparam int unsigned PICK_RANGE = 2 * WIN_BITS;
  localparam int unsigned PICK_LIMIT = FEW_SET + MANY_SET;
  localparam int unsigned ROM_BITS   = 1088;
  localparam int unsigned PAT_SPAN   = (1 << SEL_BITS) + WIN_BITS - 1;

  localparam logic [63:0] PAT_SEED = 64'h1234_5678_9abc_def0;
  localparam logic [63:0] PAT_MULT = 64'h2545_f491_4f6c_dd1d;

  // Block index bits taken from the key hash, above the window and rotate fields.
  localparam int unsigned IDX_LSB  = SEL_BITS + ROT_BITS;
  localparam int unsigned IDX_BITS = 15;

  localparam logic [3:0] BLOCK_LOG2_RESET = 4'd12;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  typedef logic [WORD_BITS-1:0] word_t;

  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] t;
    t = s;
    t = t ^ (t >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

  function automatic logic [31:0] gen_out(input logic [63:0] s);
    logic [63:0] prod;
    prod = s * PAT_MULT;
    return prod[63:32];
  endfunction

  // Seeded xorshift sliding-window build: every 57-bit window of the first
  // 1080 bits ends up holding four or five set bits.
  function automatic logic [ROM_BITS-1:0] build_pat_rom();
    logic [ROM_BITS-1:0] rom;
    logic [63:0]         st;
    int unsigned         count;
    int unsigned         live;
    int unsigned         pos;
    int unsigned         k;
    logic                placed;
    logic                out_bit;
    rom   = '0;
    st    = PAT_SEED;
    st    = xs_step(st);
    count = FEW_SET + (int'(gen_out(st)) % COUNT_SPAN);
    for (k = 0; k < count; k++) begin
      placed = 1'b0;
      while (!placed) begin
        st  = xs_step(st);
        pos = int'(gen_out(st)) % WIN_BITS;
        if (!rom[pos]) begin
          rom[pos] = 1'b1;
          placed   = 1'b1;
        end
      end
    end
    live = count;
    for (pos = WIN_BITS; pos < PAT_SPAN; pos++) begin
      out_bit = rom[pos - WIN_BITS];
      if (out_bit && live == FEW_SET) begin
        rom[pos] = 1'b1;
      end else if (out_bit || live != MANY_SET) begin
        st = xs_step(st);
        if ((int'(gen_out(st)) % PICK_RANGE) < PICK_LIMIT) begin
          rom[pos] = 1'b1;
          if (!out_bit) begin
            live++;
          end
        end else if (out_bit) begin
          live--;
        end
      end
    end
    return rom;
  endfunction

  localparam logic [ROM_BITS-1:0] PAT_ROM = build_pat_rom();

endpackage

FILE: rtl/pbbf_mask_gen.sv
// ----------------------------------------------------------------------------
// Pattern mask generator
// Two-stage pipeline: picks the two ROM words around the window start, then
// shifts out the 57-bit window and rotates it left to form the 64-bit mask.
// ----------------------------------------------------------------------------
module pbbf_mask_gen (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          sel,
  output pbbf_pkg::word_t      mask
);
  import pbbf_pkg::*;

  logic [2*WORD_BITS-1:0] win_pair;
  logic [5:0]             win_off;
  logic [ROT_BITS-1:0]    win_rot;
  logic [2*WORD_BITS-1:0] shifted;
  word_t                  win;
  logic [2*WORD_BITS-1:0] rotated;

  always_ff @(posedge clk) begin
    if (en) begin
      win_pair <= PAT_ROM[{sel[SEL_BITS-1:6], 6'd0} +: 2*WORD_BITS];
      win_off  <= sel[5:0];
      win_rot  <= sel[SEL_BITS +: ROT_BITS];
    end
  end

  always_comb begin
    shifted = win_pair >> win_off;
    win     = word_t'(shifted[WIN_BITS-1:0]);
    // Shifting the doubled word left yields a left rotate in its upper half.
    rotated = {win, win} << win_rot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask <= rotated[2*WORD_BITS-1:WORD_BITS];
    end
  end

endmodule

FILE: rtl/patterned_block_bloom_filter.sv
// A query's present bit is registered after its beat passes stages A, B and C in turn.
// Throughput: one item per cycle while the pipeline is not held; the block memory's
// read-modify-write in the last stage is forwarded to a same-cycle read of that block.
// The pipeline holds only while a finished query result waits to be taken.
// Reset: the register returns to 12 and a clearing pass writes zero to every block,
// one a cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
// Patterned blocked Bloom filter
// Inserts and queries prehashed keys against a block memory using masks cut
// from a fixed pattern ROM.
// ----------------------------------------------------------------------------
module patterned_block_bloom_filter #(
  parameter int BLOCK_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [63:0] key_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        present
);
  import pbbf_pkg::*;

  localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int NW = $clog2(BLOCK_DEPTH + 1);
  localparam int PW = IDX_BITS + NW;
  localparam int RW = NW + 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BLOCK_DEPTH);

  logic [3:0]          block_count_log2;
  logic                clearing;
  logic [AW-1:0]       clr_addr;

  logic                adv;
  logic [IDX_BITS-1:0] idx_lim;
  logic [IDX_BITS-1:0] idx_raw;
  logic [47:0]         recip_prod;

  logic                a_valid;
  logic                a_op;
  logic [15:0]         a_sel;
  logic [IDX_BITS-1:0] a_idx;
  logic [IDX_BITS-1:0] a_quot;

  logic [PW-1:0]       rem_full;
  logic [RW-1:0]       rem_est;
  logic [RW-1:0]       rem;

  logic                b_valid;
  logic                b_op;
  logic [AW-1:0]       b_addr;

  logic                c_valid;
  logic                c_op;
  logic [AW-1:0]       c_addr;
  word_t               c_mask;
  word_t               c_block;
  word_t               c_wdata;
  logic                c_write;

  logic                fwd_hit;
  word_t               fwd_data;
  word_t               rd_data;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  word_t               mem_wdata;

  word_t               bit_store [BLOCK_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count_log2 <= BLOCK_LOG2_RESET;
    end else if (cfg_wr_en) begin
      block_count_log2 <= cfg_wr_data;
    end
  end

  // The last stage moves on unless it holds a query whose result cannot be placed.
  assign adv      = !c_valid || (c_op == OP_INSERT) || !out_valid || out_ready;
  assign in_ready = adv && !clearing;

  always_comb begin
    for (int i = 0; i < IDX_BITS; i++) begin
      idx_lim[i] = (4'(i) < block_count_log2);
    end
    idx_raw    = key_hash[IDX_LSB +: IDX_BITS] & idx_lim;
    recip_prod = 48'(idx_raw) * 48'(RECIP);
  end

  // Stage A: mask the block index and estimate its quotient by BLOCK_DEPTH.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op   <= opcode;
      a_sel  <= key_hash[15:0];
      a_idx  <= idx_raw;
      a_quot <= recip_prod[32 +: IDX_BITS];
    end
  end

  // The quotient estimate is at most one short, so one correction suffices.
  always_comb begin
    rem_full = PW'(a_idx) - PW'(a_quot) * PW'(BLOCK_DEPTH);
    rem_est  = rem_full[RW-1:0];
    rem      = (rem_est >= RW'(BLOCK_DEPTH)) ? rem_est - RW'(BLOCK_DEPTH) : rem_est;
  end

  // Stage B: block address known; the memory read is issued as the stage advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op   <= a_op;
      b_addr <= rem[AW-1:0];
    end
  end

  pbbf_mask_gen u_mask_gen (
    .clk  (clk),
    .en   (adv),
    .sel  (a_sel),
    .mask (c_mask)
  );

  // Stage C: read-modify-write of the selected block.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op   <= b_op;
      c_addr <= b_addr;
    end
  end

  assign c_write = adv && c_valid && (c_op == OP_INSERT);

  always_comb begin
    c_block = fwd_hit ? fwd_data : rd_data;
    c_wdata = c_block | c_mask;
  end

  // A read in the same cycle as a write to that block misses the write, so the
  // written word is kept and used in its place.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (adv) begin
      fwd_hit <= c_write && (c_addr == b_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= c_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(BLOCK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_comb begin
    mem_we    = clearing || c_write;
    mem_waddr = clearing ? clr_addr : c_addr;
    mem_wdata = clearing ? '0 : c_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bit_store[mem_waddr] <= mem_wdata;
    end
    if (adv && b_valid) begin
      rd_data <= bit_store[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && c_valid && (c_op == OP_QUERY)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_valid && (c_op == OP_QUERY)) begin
      present <= ((c_block & c_mask) == c_mask);
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patterned blocked Bloom filter testbench
// Sends insert and query beats under several block counts and idling patterns,
// predicts each present bit from a private copy of the pattern ROM and the
// block store, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pbbf_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int PATTERN_LEN = 1088;
  localparam int SPAN_END    = 1080;
  localparam int WINDOW      = 57;
  localparam int LOW_SET     = 4;
  localparam int HIGH_SET    = 5;
  localparam logic [63:0] GEN_SEED = 64'h1234_5678_9abc_def0;
  localparam logic [63:0] GEN_MULT = 64'h2545_f491_4f6c_dd1d;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES      = 8;
  localparam int SHOWN_MAX   = 10;
  localparam int RECENT_MAX  = 32;
  localparam logic [3:0] PHASE_LOG2 [PHASES] = '{4'd12, 4'd0, 4'd15, 4'd3,
                                                 4'd13, 4'd8, 4'd1, 4'd14};

  class bloom_scoreboard;
    logic [PATTERN_LEN-1:0] pattern;
    logic [63:0]            gen;
    logic [63:0]            blocks [STORE_DEPTH];
    logic [3:0]             log2_blocks;
    logic                   present_due [$];
    int                     errors;

    function new();
      build_pattern();
      log2_blocks = 4'd12;
      foreach (blocks[i]) blocks[i] = '0;
      errors = 0;
    endfunction

    function logic [31:0] draw();
      logic [63:0] prod;
      gen  = gen ^ (gen >> 12);
      gen  = gen ^ (gen << 25);
      gen  = gen ^ (gen >> 27);
      prod = gen * GEN_MULT;
      return prod[63:32];
    endfunction

    // The first window gets four or five random bits; each later bit then keeps
    // the sliding window's population within four to five.
    function void build_pattern();
      int unsigned placed;
      int unsigned live;
      int unsigned p;
      logic        leaving;
      pattern = '0;
      gen     = GEN_SEED;
      placed  = LOW_SET + draw() % (HIGH_SET - LOW_SET + 1);
      for (int k = 0; k < placed; k++) begin
        do p = draw() % WINDOW; while (pattern[p]);
        pattern[p] = 1'b1;
      end
      live = placed;
      for (p = WINDOW; p < SPAN_END; p++) begin
        leaving = pattern[p - WINDOW];
        if (leaving && live == LOW_SET) begin
          pattern[p] = 1'b1;
        end else if (leaving || live != HIGH_SET) begin
          if (draw() % (2 * WINDOW) < LOW_SET + HIGH_SET) begin
            pattern[p] = 1'b1;
            if (!leaving) live++;
          end else if (leaving) begin
            live--;
          end
        end
      end
    endfunction

    function logic [63:0] key_mask(logic [63:0] key);
      logic [63:0]  win;
      logic [127:0] twice;
      win   = {7'b0, pattern[key[9:0] +: WINDOW]};
      twice = {win, win} << key[15:10];
      return twice[127:64];
    endfunction

    function int unsigned block_of(logic [63:0] key);
      logic [63:0] lim;
      lim = (64'd1 << log2_blocks) - 64'd1;
      return int'(((key >> 16) & lim) % STORE_DEPTH);
    endfunction

    function void note_item(opcode_t op, logic [63:0] key);
      logic [63:0] m;
      int unsigned b;
      m = key_mask(key);
      b = block_of(key);
      if (op == OP_INSERT) blocks[b] = blocks[b] | m;
      else present_due.push_back((blocks[b] & m) == m);
    endfunction

    function void check_present(logic got);
      logic want;
      if (present_due.size() == 0) begin
        errors++;
        if (errors <= SHOWN_MAX) $display("present beat %0b with no query outstanding", got);
        return;
      end
      want = present_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= SHOWN_MAX) $display("present mismatch: expected %0b, got %0b", want, got);
      end
    endfunction

    function int pending();
      return present_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [63:0] key_hash;
  logic        out_valid;
  logic        out_ready;
  logic        present;

  bloom_scoreboard sb;
  logic [63:0]     recent [$];
  int              send_idle;
  int              recv_stall;
  bit              hold_req;

  patterned_block_bloom_filter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .key_hash    (key_hash),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .present     (present)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Input beats are noted before result beats so that one edge is handled in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(opcode_t'(opcode), key_hash);
      if (out_valid && out_ready) sb.check_present(present);
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_item(opcode_t op, logic [63:0] key);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_hash <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) begin
      recent.push_back(key);
      if (recent.size() > RECENT_MAX) void'(recent.pop_front());
    end
  endtask

  // Inserts give no result, so a tail of idle clocks lets the last ones leave the pipe.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_log2(logic [3:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sb.log2_blocks = value;
    @(posedge clk);
  endtask

  // Reused keys hit the same block, either with the same mask or with a new one.
  function automatic logic [63:0] random_key();
    logic [63:0] fresh;
    logic [63:0] seen;
    int unsigned r;
    fresh = {$urandom, $urandom};
    r     = $urandom_range(99);
    if (recent.size() == 0 || r < 40) return fresh;
    seen = recent[$urandom_range(recent.size() - 1)];
    if (r < 75) return seen;
    return {seen[63:16], fresh[15:0]};
  endfunction

  initial begin
    logic [63:0] k;
    opcode_t     op;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 4'd0;
    in_valid    <= 1'b0;
    opcode      <= 1'b0;
    key_hash    <= 64'd0;
    send_idle  = 0;
    recv_stall = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_INSERT, 64'h0);
    send_item(OP_QUERY, 64'h0);
    send_item(OP_QUERY, '1);
    send_item(OP_INSERT, '1);
    send_item(OP_QUERY, '1);
    send_item(OP_QUERY, 64'h0000_0000_0000_ffff);
    send_item(OP_INSERT, 64'h0000_0000_0000_03ff);
    send_item(OP_QUERY, 64'h0000_0000_0000_03ff);
    send_item(OP_QUERY, 64'h0000_0000_0000_fc00);
    send_item(OP_INSERT, 64'h0000_0000_0001_0040);
    send_item(OP_QUERY, 64'h0000_0000_0001_0040);
    send_item(OP_QUERY, 64'h0000_0000_0001_0041);
    send_item(OP_QUERY, 64'h0000_0000_1000_0000);
    drain();
    // Register values above twelve index past the store and wrap round.
    write_log2(4'd15);
    send_item(OP_INSERT, 64'h0000_0000_4000_0123);
    send_item(OP_QUERY, 64'h0000_0000_0000_0123);
    drain();
    write_log2(4'd13);
    send_item(OP_QUERY, 64'h0000_0000_2000_0123);
    drain();
    write_log2(4'd0);
    k = {$urandom, $urandom};
    send_item(OP_INSERT, k);
    send_item(OP_QUERY, {~k[63:16], k[15:0]});
    send_item(OP_QUERY, 64'hffff_ffff_ffff_0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_log2(PHASE_LOG2[ph]);
      case (ph % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 67;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 67;
        end
        default: begin
          send_idle  = 25;
          recv_stall = 25;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) hold_req = 1'b1;
        if (ph == 5 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending() != 0) @(posedge clk);
        end
        op = ($urandom_range(1) == 1) ? OP_QUERY : OP_INSERT;
        send_item(op, random_key());
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
